// ===== hw/rtl/ehc_pkg.sv =====
`default_nettype none

package ehc_pkg;

  localparam int CNT_W_DEFAULT = 32;
  localparam int OUT_CNT_W     = 32;

  // Only bytes up to 87 are captured, so a 7-bit saturating position is enough
  localparam int POS_W = 7;

  localparam logic [POS_W-1:0] POS_ETH_HI   = 7'd12;
  localparam logic [POS_W-1:0] POS_ETH_LO   = 7'd13;
  localparam logic [POS_W-1:0] POS_IHL      = 7'd14;
  localparam logic [POS_W-1:0] POS_ARP_HI   = 7'd20;
  localparam logic [POS_W-1:0] POS_ARP_LO   = 7'd21;
  localparam logic [POS_W-1:0] POS_PROTO    = 7'd23;
  localparam logic [POS_W-1:0] L4_BASE      = 7'd14;
  localparam logic [POS_W-1:0] OFS_CODE     = 7'd1;
  localparam logic [POS_W-1:0] OFS_TCP_FLAG = 7'd13;

  localparam logic [15:0] ETH_MIN_TYPE = 16'h0600;
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETYPE_ARP    = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;

  localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
  localparam logic [7:0] IP_PROTO_TCP  = 8'd6;
  localparam logic [7:0] IP_PROTO_UDP  = 8'd17;

  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  localparam logic [3:0] IHL_MASK      = 4'hF;
  localparam logic [5:0] TCP_FLAG_MASK = 6'h3F;

  typedef enum logic [2:0] {
    EK_LENGTH = 3'd0,
    EK_IPV4   = 3'd1,
    EK_ARP    = 3'd2,
    EK_IPV6   = 3'd3,
    EK_OTHER  = 3'd4,
    EK_TRUNC  = 3'd5
  } ether_kind_t;

  typedef enum logic [2:0] {
    L4_NONE  = 3'd0,
    L4_ICMP  = 3'd1,
    L4_TCP   = 3'd2,
    L4_UDP   = 3'd3,
    L4_OTHER = 3'd4
  } l4_kind_t;

  typedef enum logic [3:0] {
    IK_ECHO_REPLY = 4'd0,
    IK_ECHO_REQ   = 4'd1,
    IK_TS_REQ     = 4'd2,
    IK_TS_REPLY   = 4'd3,
    IK_UNREACH    = 4'd4,
    IK_TIME_EXC   = 4'd5,
    IK_REDIRECT   = 4'd6,
    IK_UNKNOWN    = 4'd7,
    IK_NOT_ICMP   = 4'd8
  } icmp_kind_t;

  typedef enum logic [1:0] {
    AK_NOT_ARP = 2'd0,
    AK_REQUEST = 2'd1,
    AK_REPLY   = 2'd2,
    AK_OTHER   = 2'd3
  } arp_kind_t;

  // Which header fields a frame actually reached
  typedef struct packed {
    logic ether;
    logic ihl;
    logic proto;
    logic icmp_type;
    logic icmp_code;
    logic arp;
    logic flags;
  } seen_t;

  // Captured header fields of one finished frame
  typedef struct packed {
    logic [15:0] ether_word;
    logic [7:0]  ip_protocol;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [15:0] arp_op;
    logic [5:0]  tcp_flags;
    seen_t       seen;
  } frame_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ehc_capture.sv =====
`default_nettype none

module ehc_capture (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_frame_byte,
  input  wire logic          in_end_of_frame,
  input  wire logic          sum_take,
  output logic               sum_valid,
  output ehc_pkg::frame_t    sum_frame
);
  import ehc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]       ihl_r, ihl_nxt;
  frame_t           cur_r, cur_nxt;
  frame_t           upd;
  logic [3:0]       ihl_eff;
  logic [POS_W-1:0] base;
  logic             accept;
  logic             sum_valid_r, sum_valid_nxt;
  frame_t           sum_r, sum_nxt;

  assign in_stall = sum_valid_r && !sum_take;
  assign accept   = in_valid && !in_stall;

  // Fields as they stand once the current byte is folded in
  always_comb begin
    upd     = cur_r;
    ihl_eff = ihl_r;
    if (pos_r == POS_ETH_HI) begin
      upd.ether_word[15:8] = in_frame_byte;
    end
    if (pos_r == POS_ETH_LO) begin
      upd.ether_word[7:0] = in_frame_byte;
      upd.seen.ether      = 1'b1;
    end
    if (pos_r == POS_IHL) begin
      ihl_eff      = in_frame_byte[3:0] & IHL_MASK;
      upd.seen.ihl = 1'b1;
    end
    if (pos_r == POS_PROTO) begin
      upd.ip_protocol = in_frame_byte;
      upd.seen.proto  = 1'b1;
    end
    if (pos_r == POS_ARP_HI) begin
      upd.arp_op[15:8] = in_frame_byte;
    end
    if (pos_r == POS_ARP_LO) begin
      upd.arp_op[7:0] = in_frame_byte;
      upd.seen.arp    = 1'b1;
    end
    base = L4_BASE + {1'b0, ihl_eff, 2'b00};
    if (upd.seen.ihl) begin
      if (pos_r == base) begin
        upd.icmp_type      = in_frame_byte;
        upd.seen.icmp_type = 1'b1;
      end
      if (pos_r == base + OFS_CODE) begin
        upd.icmp_code      = in_frame_byte;
        upd.seen.icmp_code = 1'b1;
      end
      if (pos_r == base + OFS_TCP_FLAG) begin
        upd.tcp_flags  = in_frame_byte[5:0] & TCP_FLAG_MASK;
        upd.seen.flags = 1'b1;
      end
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    ihl_nxt       = ihl_r;
    cur_nxt       = cur_r;
    sum_nxt       = sum_r;
    sum_valid_nxt = sum_valid_r && !sum_take;
    if (accept) begin
      if (in_end_of_frame) begin
        // hand the frame on and start the next one clean
        sum_nxt       = upd;
        sum_valid_nxt = 1'b1;
        pos_nxt       = '0;
        ihl_nxt       = '0;
        cur_nxt       = '0;
      end else begin
        pos_nxt = (pos_r == {POS_W{1'b1}}) ? pos_r : pos_r + 1'b1;
        ihl_nxt = ihl_eff;
        cur_nxt = upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ihl_r       <= '0;
      cur_r       <= '0;
      sum_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      ihl_r       <= ihl_nxt;
      cur_r       <= cur_nxt;
      sum_valid_r <= sum_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum_valid = sum_valid_r;
  assign sum_frame = sum_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ehc_classify.sv =====
`default_nettype none

module ehc_classify #(
  parameter int COUNT_WIDTH = ehc_pkg::CNT_W_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            sum_valid,
  input  wire ehc_pkg::frame_t sum_frame,
  output logic                 sum_take,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [2:0]           out_ether_kind,
  output logic [2:0]           out_l4_kind,
  output logic [3:0]           out_icmp_kind,
  output logic [1:0]           out_arp_op_kind,
  output logic [15:0]          out_type_len,
  output logic [5:0]           out_tcp_flag_bits,
  output logic [31:0]          out_frames_seen,
  output logic [31:0]          out_ipv4_seen,
  output logic [31:0]          out_arp_seen,
  output logic [31:0]          out_icmp_seen,
  output logic [31:0]          out_tcp_seen,
  output logic [31:0]          out_udp_seen
);
  import ehc_pkg::*;

  function automatic icmp_kind_t classify_icmp(input logic [7:0] t, input logic [7:0] c);
    icmp_kind_t k;
    k = IK_UNKNOWN;
    if (t == 8'd0 && c == 8'd0) begin
      k = IK_ECHO_REPLY;
    end else if (t == 8'd8 && c == 8'd0) begin
      k = IK_ECHO_REQ;
    end else if (t == 8'd13 && c == 8'd0) begin
      k = IK_TS_REQ;
    end else if (t == 8'd14 && c == 8'd0) begin
      k = IK_TS_REPLY;
    end else if (t == 8'd3 && c <= 8'd15) begin
      k = IK_UNREACH;
    end else if (t == 8'd11 && c <= 8'd1) begin
      k = IK_TIME_EXC;
    end else if (t == 8'd5 && c <= 8'd3) begin
      k = IK_REDIRECT;
    end
    return k;
  endfunction

  logic out_valid_r, out_valid_nxt;
  logic load;

  logic [COUNT_WIDTH-1:0] frames_r, ipv4_r, arp_r, icmp_r, tcp_r, udp_r;
  logic [COUNT_WIDTH-1:0] frames_nxt, ipv4_nxt, arp_nxt, icmp_nxt, tcp_nxt, udp_nxt;

  ether_kind_t ek;
  l4_kind_t    l4;
  icmp_kind_t  ik;
  arp_kind_t   ak;
  logic [5:0]  flags;
  logic [15:0] tol;

  ether_kind_t ek_r;
  l4_kind_t    l4_r;
  icmp_kind_t  ik_r;
  arp_kind_t   ak_r;
  logic [5:0]  flags_r;
  logic [15:0] tol_r;

  assign sum_take = !out_valid_r || !out_stall;
  assign load     = sum_valid && sum_take;

  always_comb begin
    ek    = EK_TRUNC;
    l4    = L4_NONE;
    ik    = IK_NOT_ICMP;
    ak    = AK_NOT_ARP;
    flags = '0;
    tol   = sum_frame.seen.ether ? sum_frame.ether_word : 16'd0;
    if (sum_frame.seen.ether) begin
      if (sum_frame.ether_word < ETH_MIN_TYPE) begin
        ek = EK_LENGTH;
      end else if (sum_frame.ether_word == ETYPE_IPV4) begin
        ek = EK_IPV4;
      end else if (sum_frame.ether_word == ETYPE_ARP) begin
        ek = EK_ARP;
      end else if (sum_frame.ether_word == ETYPE_IPV6) begin
        ek = EK_IPV6;
      end else begin
        ek = EK_OTHER;
      end
    end
    if (ek == EK_ARP) begin
      if (sum_frame.seen.arp && sum_frame.arp_op == ARP_OP_REQUEST) begin
        ak = AK_REQUEST;
      end else if (sum_frame.seen.arp && sum_frame.arp_op == ARP_OP_REPLY) begin
        ak = AK_REPLY;
      end else begin
        ak = AK_OTHER;
      end
    end
    if (ek == EK_IPV4 && sum_frame.seen.proto) begin
      if (sum_frame.ip_protocol == IP_PROTO_ICMP) begin
        l4 = L4_ICMP;
      end else if (sum_frame.ip_protocol == IP_PROTO_TCP) begin
        l4 = L4_TCP;
      end else if (sum_frame.ip_protocol == IP_PROTO_UDP) begin
        l4 = L4_UDP;
      end else begin
        l4 = L4_OTHER;
      end
    end
    if (l4 == L4_ICMP) begin
      ik = (sum_frame.seen.icmp_type && sum_frame.seen.icmp_code)
           ? classify_icmp(sum_frame.icmp_type, sum_frame.icmp_code) : IK_UNKNOWN;
    end
    if (l4 == L4_TCP && sum_frame.seen.flags) begin
      flags = sum_frame.tcp_flags;
    end
  end

  // Counters include the frame being reported
  always_comb begin
    frames_nxt = frames_r;
    ipv4_nxt   = ipv4_r;
    arp_nxt    = arp_r;
    icmp_nxt   = icmp_r;
    tcp_nxt    = tcp_r;
    udp_nxt    = udp_r;
    if (load) begin
      frames_nxt = frames_r + 1'b1;
      if (ek == EK_IPV4) ipv4_nxt = ipv4_r + 1'b1;
      if (ek == EK_ARP)  arp_nxt  = arp_r + 1'b1;
      if (l4 == L4_ICMP) icmp_nxt = icmp_r + 1'b1;
      if (l4 == L4_TCP)  tcp_nxt  = tcp_r + 1'b1;
      if (l4 == L4_UDP)  udp_nxt  = udp_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      frames_r    <= '0;
      ipv4_r      <= '0;
      arp_r       <= '0;
      icmp_r      <= '0;
      tcp_r       <= '0;
      udp_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      frames_r    <= frames_nxt;
      ipv4_r      <= ipv4_nxt;
      arp_r       <= arp_nxt;
      icmp_r      <= icmp_nxt;
      tcp_r       <= tcp_nxt;
      udp_r       <= udp_nxt;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      ek_r    <= ek;
      l4_r    <= l4;
      ik_r    <= ik;
      ak_r    <= ak;
      flags_r <= flags;
      tol_r   <= tol;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ether_kind     = ek_r;
  assign out_l4_kind        = l4_r;
  assign out_icmp_kind      = ik_r;
  assign out_arp_op_kind    = ak_r;
  assign out_type_len       = tol_r;
  assign out_tcp_flag_bits  = flags_r;
  assign out_frames_seen    = OUT_CNT_W'(frames_r);
  assign out_ipv4_seen      = OUT_CNT_W'(ipv4_r);
  assign out_arp_seen       = OUT_CNT_W'(arp_r);
  assign out_icmp_seen      = OUT_CNT_W'(icmp_r);
  assign out_tcp_seen       = OUT_CNT_W'(tcp_r);
  assign out_udp_seen       = OUT_CNT_W'(udp_r);

endmodule

`default_nettype wire

// ===== hw/rtl/ethernet_ip_header_classifier_top.sv =====
`default_nettype none

// Ethernet/IPv4 header classifier. Takes one frame byte per clock, destination
// address first, with in_end_of_frame on the last byte, and returns one result
// per frame: ethertype class, layer-4 class, ICMP kind, ARP operation kind,
// the type/length word, TCP flags and six running frame counters that include
// the frame reported. Byte throughput is one per clock while in_stall is low,
// with no gaps needed between frames. The result is registered in the header
// capture register, then in the classify/result register. in_stall rises only
// when a finished frame summary is held behind a stalled result. Counters are
// COUNT_WIDTH bits wide and wrap; the ports show their low 32 bits.
module ethernet_ip_header_classifier_top #(
  parameter int COUNT_WIDTH = ehc_pkg::CNT_W_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_frame_byte,
  input  wire logic        in_end_of_frame,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_ether_kind,
  output logic [2:0]       out_l4_kind,
  output logic [3:0]       out_icmp_kind,
  output logic [1:0]       out_arp_op_kind,
  output logic [15:0]      out_type_len,
  output logic [5:0]       out_tcp_flag_bits,
  output logic [31:0]      out_frames_seen,
  output logic [31:0]      out_ipv4_seen,
  output logic [31:0]      out_arp_seen,
  output logic [31:0]      out_icmp_seen,
  output logic [31:0]      out_tcp_seen,
  output logic [31:0]      out_udp_seen
);
  import ehc_pkg::*;

  logic   sum_valid;
  logic   sum_take;
  frame_t sum_frame;

  ehc_capture u_capture (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_frame_byte   (in_frame_byte),
    .in_end_of_frame (in_end_of_frame),
    .sum_take        (sum_take),
    .sum_valid       (sum_valid),
    .sum_frame       (sum_frame)
  );

  ehc_classify #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_classify (
    .clk                (clk),
    .rst_n              (rst_n),
    .sum_valid          (sum_valid),
    .sum_frame          (sum_frame),
    .sum_take           (sum_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ether_kind     (out_ether_kind),
    .out_l4_kind        (out_l4_kind),
    .out_icmp_kind      (out_icmp_kind),
    .out_arp_op_kind    (out_arp_op_kind),
    .out_type_len       (out_type_len),
    .out_tcp_flag_bits  (out_tcp_flag_bits),
    .out_frames_seen    (out_frames_seen),
    .out_ipv4_seen      (out_ipv4_seen),
    .out_arp_seen       (out_arp_seen),
    .out_icmp_seen      (out_icmp_seen),
    .out_tcp_seen       (out_tcp_seen),
    .out_udp_seen       (out_udp_seen)
  );

endmodule

`default_nettype wire
